[sv/bglu_pkg.sv]
// ---------------------------------------------------------------------------
// bglu_pkg
// Shared types and codes for the binary GCD / LCM unit.
// ---------------------------------------------------------------------------
package bglu_pkg;

	// opcode carried in the input tuser
	localparam logic OP_GCD = 1'b0;
	localparam logic OP_LCM = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_STRIP2,
		ST_STRIPA,
		ST_STRIPB,
		ST_SUB,
		ST_SCALE,
		ST_DIV,
		ST_MUL,
		ST_FINISH
	} bglu_state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[sv/bglu_divider.sv]
// ---------------------------------------------------------------------------
// bglu_divider
// Restoring divider, one quotient bit per cycle. Quotient holds after done.
// ---------------------------------------------------------------------------
module bglu_divider #(
	parameter int OPERAND_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] dividend,
	input  logic [OPERAND_BITS-1:0] divisor,
	output logic [OPERAND_BITS-1:0] quotient,
	output bglu_pkg::div_stat_t     stat
);

	localparam int W    = OPERAND_BITS;
	localparam int CNTW = $clog2(W + 1);

	logic [W:0]      rem_q;
	logic [W-1:0]    quo_q;
	logic [W-1:0]    den_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [W:0]      shifted;
	logic [W:0]      trial;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

[sv/binary_gcd_lcm_unit_top.sv]
// ---------------------------------------------------------------------------
// binary_gcd_lcm_unit_top
// GCD by Stein's binary method, LCM as (a / gcd) * b, one item at a time.
// ---------------------------------------------------------------------------
// channel   dir  tdata                         tuser
// s_axis    in   operand_a, operand_b          opcode
// m_axis    out  answer (2*OPERAND_BITS bits)  -
//
// GCD: a zero operand goes from the check straight to the finish state, else
// common twos are stripped, then each round shifts and subtracts (subtract,
// odd test). LCM: the GCD, then a divider run and a multiply step; a zero
// operand finishes as for GCD. s_axis_tready is high only when idle.
// The result register frees the sequencer; it stalls in its last state only
// while an earlier answer is still not taken. Reset clears control state only.
// ---------------------------------------------------------------------------
module binary_gcd_lcm_unit_top #(
	parameter int OPERAND_BITS = 31
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// operand_a, operand_b, zero pad
	input  logic [8*((2*OPERAND_BITS+7)/8)-1:0] s_axis_tdata,
	// opcode
	input  logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// answer, zero pad
	output logic [8*((2*OPERAND_BITS+7)/8)-1:0] m_axis_tdata
);

	localparam int W     = OPERAND_BITS;
	localparam int DW    = 8 * ((2 * W + 7) / 8);
	localparam int TWOSW = $clog2(W);

	bglu_pkg::bglu_state_t state_q, state_d;
	bglu_pkg::div_stat_t   div_stat;

	logic [W-1:0]     x_q, y_q, ia_q, ib_q;
	logic [TWOSW-1:0] twos_q;
	logic             op_q;
	logic [2*W-1:0]   res_q, ans_q;
	logic             out_valid_q;
	logic             div_start;
	logic             load_out;
	logic [W-1:0]     quot;
	logic [W-1:0]     gcd_val;
	logic             x_gt_y;
	logic [W-1:0]     diff;

	// compare/subtract unit for the subtract step
	assign x_gt_y  = x_q > y_q;
	assign diff    = x_gt_y ? (x_q - y_q) : (y_q - x_q);
	assign gcd_val = x_q << twos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bglu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			bglu_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) state_d = bglu_pkg::ST_CHECK;
			end
			bglu_pkg::ST_CHECK: begin
				if (x_q == '0 || y_q == '0) state_d = bglu_pkg::ST_FINISH;
				else                        state_d = bglu_pkg::ST_STRIP2;
			end
			bglu_pkg::ST_STRIP2: begin
				if (x_q[0] | y_q[0]) state_d = bglu_pkg::ST_STRIPA;
			end
			bglu_pkg::ST_STRIPA: begin
				if (x_q[0]) state_d = bglu_pkg::ST_STRIPB;
			end
			bglu_pkg::ST_STRIPB: begin
				if (y_q == '0)   state_d = bglu_pkg::ST_SCALE;
				else if (y_q[0]) state_d = bglu_pkg::ST_SUB;
			end
			bglu_pkg::ST_SUB: begin
				state_d = bglu_pkg::ST_STRIPB;
			end
			bglu_pkg::ST_SCALE: begin
				if (op_q == bglu_pkg::OP_LCM) begin
					div_start = 1'b1;
					state_d   = bglu_pkg::ST_DIV;
				end else begin
					state_d = bglu_pkg::ST_FINISH;
				end
			end
			bglu_pkg::ST_DIV: begin
				if (div_stat.done) state_d = bglu_pkg::ST_MUL;
			end
			bglu_pkg::ST_MUL: begin
				state_d = bglu_pkg::ST_FINISH;
			end
			bglu_pkg::ST_FINISH: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = bglu_pkg::ST_IDLE;
				end
			end
			default: state_d = bglu_pkg::ST_IDLE;
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bglu_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					op_q   <= s_axis_tuser[0];
					x_q    <= s_axis_tdata[W-1:0];
					y_q    <= s_axis_tdata[2*W-1:W];
					ia_q   <= s_axis_tdata[W-1:0];
					ib_q   <= s_axis_tdata[2*W-1:W];
					twos_q <= '0;
				end
			end
			bglu_pkg::ST_CHECK: begin
				// gcd(0,x) = x; lcm with a zero operand is 0
				if (op_q == bglu_pkg::OP_LCM) res_q <= '0;
				else                          res_q <= (2*W)'(x_q | y_q);
			end
			bglu_pkg::ST_STRIP2: begin
				if (!(x_q[0] | y_q[0])) begin
					x_q    <= x_q >> 1;
					y_q    <= y_q >> 1;
					twos_q <= twos_q + TWOSW'(1);
				end
			end
			bglu_pkg::ST_STRIPA: begin
				if (!x_q[0]) x_q <= x_q >> 1;
			end
			bglu_pkg::ST_STRIPB: begin
				if (y_q != '0 && !y_q[0]) y_q <= y_q >> 1;
			end
			bglu_pkg::ST_SUB: begin
				if (x_gt_y) x_q <= y_q;
				y_q <= diff;
			end
			bglu_pkg::ST_SCALE: begin
				res_q <= (2*W)'(gcd_val);
			end
			bglu_pkg::ST_MUL: begin
				res_q <= (2*W)'(quot) * (2*W)'(ib_q);
			end
			default: ;
		endcase
	end

	bglu_divider #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ia_q),
		.divisor  (gcd_val),
		.quotient (quot),
		.stat     (div_stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) ans_q <= res_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DW'(ans_q);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("accepted a new item while busy");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	a_sub_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bglu_pkg::ST_SUB) |-> (x_q[0] && y_q[0]))
		else $error("subtract step on an even operand");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == bglu_pkg::ST_DIV))
		else $error("divider finished outside its wait state");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for binary_gcd_lcm_unit_top. Operand pairs go in on the
// input stream with the opcode in tuser. Each answer coming out is compared
// with a GCD or LCM worked out here in advance, in arrival order.
// ---------------------------------------------------------------------------
module testbench;

	localparam int OPB = 31;
	localparam int ANSB = 2 * OPB;
	localparam int BUS_W = 8 * ((ANSB + 7) / 8);
	localparam logic [OPB-1:0] OPMAX = {OPB{1'b1}};
	localparam int STALL_LIMIT = 50000;
	localparam int DRAIN_CYCLES = 128;

	typedef logic [OPB-1:0] operand_t;
	typedef logic [ANSB-1:0] answer_t;

	class answer_scoreboard;
		answer_t expected_q[$];
		int mismatches = 0;

		// Stein's method, then lcm as (a / gcd) * b at full width
		function answer_t gcd_lcm(logic op, operand_t a, operand_t b);
			operand_t x, y, t;
			int twos;
			answer_t g, quot;
			x = a;
			y = b;
			twos = 0;
			if (a == 0 || b == 0) begin
				g = answer_t'(a | b);
			end else begin
				while (!x[0] && !y[0]) begin
					x = x >> 1;
					y = y >> 1;
					twos++;
				end
				while (!x[0])
					x = x >> 1;
				while (y != 0) begin
					while (!y[0])
						y = y >> 1;
					if (x > y) begin
						t = x;
						x = y;
						y = t;
					end
					y = y - x;
				end
				g = answer_t'(x) << twos;
			end
			if (op == bglu_pkg::OP_GCD)
				return g;
			if (a == 0 || b == 0)
				return '0;
			quot = answer_t'(a) / g;
			return quot * answer_t'(b);
		endfunction

		function void note_request(logic op, operand_t a, operand_t b);
			expected_q.push_back(gcd_lcm(op, a, b));
		endfunction

		function void check_answer(answer_t actual);
			answer_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected answer %0d", $realtime, actual);
				return;
			end
			want = expected_q.pop_front();
			if (actual !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: answer mismatch, expected %0d, actual %0d",
						$realtime, want, actual);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [BUS_W-1:0] s_axis_tdata;	// operand_a, operand_b, zero pad
	logic [0:0] s_axis_tuser;	// opcode
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [BUS_W-1:0] m_axis_tdata;	// answer, zero pad

	answer_scoreboard sb;
	int send_idle;
	int recv_idle;
	int stall_cycles;

	binary_gcd_lcm_unit_top #(
		.OPERAND_BITS(OPB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// result side: sample at the edge, then pick next cycle's ready
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_answer(m_axis_tdata[ANSB-1:0]);
		m_axis_tready <= (arst_n && $urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL binary_gcd_lcm_unit_top");
			$finish;
		end
	end

	task automatic send_item(logic op, operand_t a, operand_t b);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {{(BUS_W - ANSB){1'b0}}, b, a};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_request(op, a, b);
	endtask

	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic operand_t rand_bits(int n);
		operand_t v;
		v = operand_t'($urandom);
		if (n < OPB)
			v = v & ((operand_t'(1) << n) - 1);
		return v;
	endfunction

	task automatic send_random(int count);
		int kind, gw;
		operand_t a, b, g;
		logic op;
		for (int i = 0; i < count; i++) begin
			op = $urandom_range(1) ? bglu_pkg::OP_LCM : bglu_pkg::OP_GCD;
			kind = $urandom_range(99);
			if (kind < 30) begin
				a = rand_bits(OPB);
				b = rand_bits(OPB);
			end else if (kind < 65) begin
				// shared factor, products stay inside the operand width
				gw = $urandom_range(1, 15);
				g = rand_bits(gw) | 1'b1;
				a = g * rand_bits($urandom_range(1, OPB - gw));
				b = g * rand_bits($urandom_range(1, OPB - gw));
			end else if (kind < 80) begin
				gw = $urandom_range(1, 20);
				a = rand_bits(OPB - gw) << gw;
				b = rand_bits(OPB - $urandom_range(0, gw)) << $urandom_range(0, gw);
			end else if (kind < 90) begin
				a = rand_bits(8);
				b = rand_bits(8);
			end else if (kind < 95) begin
				a = $urandom_range(1) ? '0 : rand_bits(OPB);
				b = (a == 0 && $urandom_range(1)) ? rand_bits(OPB) : '0;
			end else begin
				a = $urandom_range(1) ? OPMAX : rand_bits(OPB);
				case ($urandom_range(2))
					0: b = a;
					1: b = operand_t'(1);
					default: b = OPMAX - rand_bits(4);
				endcase
			end
			if ($urandom_range(1))
				{a, b} = {b, a};
			send_item(op, a, b);
			if ($urandom_range(149) == 0)
				wait_drain();
		end
	endtask

	initial begin
		sb = new();
		send_idle = 37;
		recv_idle = 88;
		stall_cycles = 0;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= bglu_pkg::OP_GCD;
		m_axis_tready <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero operands, extremes, powers of two, common twos, equal values
		for (int k = 0; k < 2; k++) begin
			logic op_k;
			op_k = k ? bglu_pkg::OP_LCM : bglu_pkg::OP_GCD;
			send_item(op_k, '0, '0);
			send_item(op_k, '0, operand_t'(12));
			send_item(op_k, OPMAX, '0);
			send_item(op_k, OPMAX, OPMAX);
			send_item(op_k, OPMAX, OPMAX - 1);
			send_item(op_k, operand_t'(1) << (OPB - 1), operand_t'(1) << 7);
			send_item(op_k, operand_t'(96), operand_t'(40));
			send_item(op_k, operand_t'(1), OPMAX - 2);
			send_item(op_k, operand_t'(65537), operand_t'(65521));
			send_item(op_k, operand_t'(31'h2AAAAAAA), operand_t'(31'h55555555));
		end
		send_random(610);
		wait_drain();

		send_idle = 88;
		recv_idle = 37;
		send_random(630);
		wait_drain();

		send_idle = 0;
		recv_idle = 0;
		send_random(640);
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("PASS binary_gcd_lcm_unit_top");
		else
			$display("FAIL binary_gcd_lcm_unit_top");
		$finish;
	end

endmodule

[binary_gcd_lcm_unit_top.f]
sv/bglu_pkg.sv
sv/bglu_divider.sv
sv/binary_gcd_lcm_unit_top.sv
tb/testbench.sv
